>>> rtl/core/hlf_pkg.sv
// hlf_pkg: shared types, character constants and the hex digit function
// for the hex line framer; no dependencies
`timescale 1ns / 1ps

package hlf_pkg;

   localparam int unsigned SLOT_CHARS = 8;
   localparam int unsigned IDX_W      = 3;

   localparam logic [7:0] CH_SEP     = 8'h2D;  // '-'
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
   localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
   localparam logic [3:0] NIB_TEN    = 4'hA;

   // input item kinds carried on the request user bit
   typedef enum logic {
      ACT_BEGIN = 1'b0,
      ACT_DATA  = 1'b1
   } action_type;

   // all characters one input item produces, ready for the serializer
   typedef struct packed {
      logic [SLOT_CHARS-1:0][7:0] chars;
      logic [IDX_W-1:0]           last_idx;
      logic                       closes;
      logic                       valid;
   } slot_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < NIB_TEN) begin
         hex_char = wide + CH_ZERO;
      end else begin
         hex_char = wide - {4'h0, NIB_TEN} + CH_UPPER_A;
      end
   endfunction

endpackage

>>> rtl/core/hex_line_framer_with_sum_checksum.sv
// hex_line_framer_with_sum_checksum: top level of the hex line framer
// depends on hlf_pkg, hlf_encoder and hlf_serializer
//
// usage:
//   req channel: one transfer per item; req_tuser is the action (0 begins
//   a block, 1 carries a data byte), req_tdata holds the value and, on a
//   begin, the block length
//   rsp channel: one transfer per output character; rsp_tlast marks the
//   last character of an input item, rsp_tuser marks the closing line feed
//   a begin gives start byte, length in hex and '-' (length 0 also closes
//   the line as below); each data byte gives two hex characters, plus '-'
//   after every GROUP_BYTES bytes; the last byte closes the line with '-',
//   the 8-bit sum in hex and a line feed; data outside a block gives none
// timing:
//   characters pass through the holding slot, then the output register
//   one character per cycle while rsp is not stalled; a data item gives 2, 3
//   or 6 characters and a begin item 4 or 8; the next item is taken in the
//   cycle its predecessor's last character moves into the output register
//   the single output character register sets the rate
// reset: synchronous, clears the open block, the sum and both valid flags
// stall: while rsp_tready is low the character register holds, one item's
//   characters wait in the holding slot and req_tready drops once it fills
`timescale 1ns / 1ps

module hex_line_framer_with_sum_checksum #(
   parameter int unsigned GROUP_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] value, [15:8] block_length
   input  logic        req_tuser,   // [0] action

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] character
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] line_done
);

   hlf_pkg::slot_type slot;
   logic              accept;
   logic              free;

   // an item is taken whenever the holding slot is empty or empties now
   assign req_tready = free;
   assign accept     = req_tvalid && free;

   // frame state and per-item character build
   hlf_encoder #(
      .GROUP_BYTES (GROUP_BYTES)
   ) u_encoder (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_tuser),
      .value        (req_tdata[7:0]),
      .block_length (req_tdata[15:8]),
      .slot         (slot)
   );

   // holding slot and output character register
   hlf_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .slot_in   (slot),
      .free      (free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_done  (rsp_tuser)
   );

endmodule

>>> rtl/core/hlf_encoder.sv
// hlf_encoder: frame state (open block, byte count, group position, sum)
// and the character set each accepted item produces; uses hlf_pkg
`timescale 1ns / 1ps

module hlf_encoder #(
   parameter int unsigned GROUP_BYTES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             action,
   input  logic [7:0]       value,
   input  logic [7:0]       block_length,
   output hlf_pkg::slot_type slot
);

   localparam int unsigned GW = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
   localparam logic [GW-1:0] GROUP_END = GW'(GROUP_BYTES - 1);

   logic          active_ff,      active_in;
   logic [7:0]    byte_count_ff,  byte_count_in;
   logic [7:0]    length_held_ff, length_held_in;
   logic [7:0]    running_sum_ff, running_sum_in;
   logic [GW-1:0] group_ff,       group_in;

   logic [7:0] seed_sum;
   logic [7:0] data_sum;
   logic [7:0] count_next;
   logic       data_close;
   logic       group_wrap;

   assign seed_sum   = value + block_length;
   assign data_sum   = running_sum_ff + value;
   assign count_next = byte_count_ff + 8'd1;
   assign data_close = (count_next >= length_held_ff);
   assign group_wrap = (group_ff == GROUP_END);

   always_comb begin
      active_in      = active_ff;
      byte_count_in  = byte_count_ff;
      length_held_in = length_held_ff;
      running_sum_in = running_sum_ff;
      group_in       = group_ff;

      slot.chars    = '0;
      slot.last_idx = '0;
      slot.closes   = 1'b0;
      slot.valid    = 1'b0;

      if (hlf_pkg::action_type'(action) == hlf_pkg::ACT_BEGIN) begin
         active_in      = (block_length != 8'd0);
         byte_count_in  = 8'd0;
         length_held_in = block_length;
         running_sum_in = seed_sum;
         group_in       = '0;
         slot.valid     = 1'b1;
         slot.chars[0]  = value;
         slot.chars[1]  = hlf_pkg::hex_char(block_length[7:4]);
         slot.chars[2]  = hlf_pkg::hex_char(block_length[3:0]);
         slot.chars[3]  = hlf_pkg::CH_SEP;
         slot.chars[4]  = hlf_pkg::CH_SEP;
         slot.chars[5]  = hlf_pkg::hex_char(seed_sum[7:4]);
         slot.chars[6]  = hlf_pkg::hex_char(seed_sum[3:0]);
         slot.chars[7]  = hlf_pkg::CH_LF;
         // empty block closes the line right away
         if (block_length == 8'd0) begin
            slot.last_idx = 3'd7;
            slot.closes   = 1'b1;
         end else begin
            slot.last_idx = 3'd3;
         end
      end else if (active_ff) begin
         byte_count_in  = count_next;
         running_sum_in = data_sum;
         group_in       = group_wrap ? '0 : group_ff + GW'(1);
         slot.valid     = 1'b1;
         slot.chars[0]  = hlf_pkg::hex_char(value[7:4]);
         slot.chars[1]  = hlf_pkg::hex_char(value[3:0]);
         slot.chars[2]  = hlf_pkg::CH_SEP;
         slot.chars[3]  = hlf_pkg::hex_char(data_sum[7:4]);
         slot.chars[4]  = hlf_pkg::hex_char(data_sum[3:0]);
         slot.chars[5]  = hlf_pkg::CH_LF;
         if (data_close) begin
            active_in     = 1'b0;
            slot.last_idx = 3'd5;
            slot.closes   = 1'b1;
         end else if (group_wrap) begin
            slot.last_idx = 3'd2;
         end else begin
            slot.last_idx = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         byte_count_ff  <= 8'd0;
         length_held_ff <= 8'd0;
         running_sum_ff <= 8'd0;
         group_ff       <= '0;
      end else if (accept) begin
         active_ff      <= active_in;
         byte_count_ff  <= byte_count_in;
         length_held_ff <= length_held_in;
         running_sum_ff <= running_sum_in;
         group_ff       <= group_in;
      end
   end

endmodule

>>> rtl/core/hlf_serializer.sv
// hlf_serializer: holds one item's characters and sends them one per
// cycle unless stalled, via a registered output stage; uses hlf_pkg
`timescale 1ns / 1ps

module hlf_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  hlf_pkg::slot_type slot_in,
   output logic              free,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_char,
   output logic              out_last,
   output logic              out_done
);

   hlf_pkg::slot_type           slot_ff;
   logic                        slot_valid_ff, slot_valid_in;
   logic [hlf_pkg::IDX_W-1:0]   idx_ff,        idx_in;
   logic                        out_valid_ff,  out_valid_in;
   logic [7:0]                  out_char_ff;
   logic                        out_last_ff;
   logic                        out_done_ff;

   logic step;
   logic at_last;

   assign at_last = (idx_ff == slot_ff.last_idx);
   assign step    = slot_valid_ff && (!out_valid_ff || out_ready);
   assign free    = !slot_valid_ff || (step && at_last);

   always_comb begin
      slot_valid_in = slot_valid_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      if (step) begin
         out_valid_in = 1'b1;
         idx_in       = at_last ? '0 : idx_ff + 3'd1;
         if (at_last) begin
            slot_valid_in = 1'b0;
         end
      end
      if (load && slot_in.valid) begin
         slot_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= slot_in;
      end
      if (step) begin
         out_char_ff <= slot_ff.chars[idx_ff];
         out_last_ff <= at_last;
         out_done_ff <= at_last && slot_ff.closes;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;
   assign out_done  = out_done_ff;

endmodule
